/* sv/mkq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkq_pkg
// Shared types, constants and the Morse code table for the QRSS/DFCW keyer.
// ----------------------------------------------------------------------------
package mkq_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int DUR_W       = 22;
   localparam int CODE_LEN_W  = 3;
   localparam int CODE_MAX    = 7;

   localparam logic [DUR_W-1:0] MS_PER_S = 22'd1000;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TX_MODE      = 3'd0,
      CSR_DOT_TIME     = 3'd1,
      CSR_DASH_RATIO   = 3'd2,
      CSR_GAP_TIME     = 3'd3,
      CSR_PTT_DELAY    = 3'd4,
      CSR_BEACON_PAUSE = 3'd5,
      CSR_SIDETONE_EN  = 3'd6,
      CSR_BEACON_FLAGS = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      TONE_NONE = 2'd0,
      TONE_SIDE = 2'd1,
      TONE_DOT  = 2'd2,
      TONE_DASH = 2'd3
   } tone_type;

   typedef struct packed {
      logic        tx_mode;
      logic [15:0] dot_time_ms;
      logic [3:0]  dash_ratio;
      logic [15:0] gap_time_ms;
      logic [15:0] ptt_delay_ms;
      logic [11:0] beacon_pause_s;
      logic        sidetone_en;
      logic [1:0]  beacon_flags;
   } cfg_type;

   // one Morse code; pattern is left aligned, bit 6 is the first element, 1 = dash
   typedef struct packed {
      logic                  found;
      logic                  space;
      logic [CODE_LEN_W-1:0] len;
      logic [CODE_MAX-1:0]   pattern;
   } morse_code_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_LEAD,
      ST_BAD,
      ST_ELEM,
      ST_EGAP,
      ST_LGAP,
      ST_END,
      ST_STOP
   } state_type;

   typedef enum logic [2:0] {
      SEG_LEAD,
      SEG_BAD,
      SEG_ELEM,
      SEG_EGAP,
      SEG_LGAP,
      SEG_END,
      SEG_STOP
   } seg_type;

   typedef struct packed {
      logic    load;
      logic    emit;
      seg_type seg;
      logic    last;
      logic    idx_adv;
   } ctrl_cmd_type;

   typedef struct packed {
      logic stop;
      logic active;
      logic bad;
      logic last_char;
      logic elem_last;
      logic gap_after;
      logic out_free;
   } dp_status_type;

   function automatic morse_code_type mk_code(input logic [CODE_LEN_W-1:0] len,
                                              input logic [CODE_MAX-1:0] pattern);
      morse_code_type c;
      c.found   = 1'b1;
      c.space   = 1'b0;
      c.len     = len;
      c.pattern = pattern;
      return c;
   endfunction

   // case-insensitive lookup of one character
   function automatic morse_code_type code_lookup(input logic [7:0] ch);
      logic [7:0]     uc;
      morse_code_type c;
      uc = ch;
      if (ch >= "a" && ch <= "z") begin
         uc = ch - 8'd32;
      end
      c = '0;
      case (uc)
         "A": c = mk_code(3'd2, 7'b0100000);
         "B": c = mk_code(3'd4, 7'b1000000);
         "C": c = mk_code(3'd4, 7'b1010000);
         "D": c = mk_code(3'd3, 7'b1000000);
         "E": c = mk_code(3'd1, 7'b0000000);
         "F": c = mk_code(3'd4, 7'b0010000);
         "G": c = mk_code(3'd3, 7'b1100000);
         "H": c = mk_code(3'd4, 7'b0000000);
         "I": c = mk_code(3'd2, 7'b0000000);
         "J": c = mk_code(3'd4, 7'b0111000);
         "K": c = mk_code(3'd3, 7'b1010000);
         "L": c = mk_code(3'd4, 7'b0100000);
         "M": c = mk_code(3'd2, 7'b1100000);
         "N": c = mk_code(3'd2, 7'b1000000);
         "O": c = mk_code(3'd3, 7'b1110000);
         "P": c = mk_code(3'd4, 7'b0110000);
         "Q": c = mk_code(3'd4, 7'b1101000);
         "R": c = mk_code(3'd3, 7'b0100000);
         "S": c = mk_code(3'd3, 7'b0000000);
         "T": c = mk_code(3'd1, 7'b1000000);
         "U": c = mk_code(3'd3, 7'b0010000);
         "V": c = mk_code(3'd4, 7'b0001000);
         "W": c = mk_code(3'd3, 7'b0110000);
         "X": c = mk_code(3'd4, 7'b1001000);
         "Y": c = mk_code(3'd4, 7'b1011000);
         "Z": c = mk_code(3'd4, 7'b1100000);
         "0": c = mk_code(3'd5, 7'b1111100);
         "1": c = mk_code(3'd5, 7'b0111100);
         "2": c = mk_code(3'd5, 7'b0011100);
         "3": c = mk_code(3'd5, 7'b0001100);
         "4": c = mk_code(3'd5, 7'b0000100);
         "5": c = mk_code(3'd5, 7'b0000000);
         "6": c = mk_code(3'd5, 7'b1000000);
         "7": c = mk_code(3'd5, 7'b1100000);
         "8": c = mk_code(3'd5, 7'b1110000);
         "9": c = mk_code(3'd5, 7'b1111000);
         "?": c = mk_code(3'd6, 7'b0011000);
         "/": c = mk_code(3'd5, 7'b1001000);
         ".": c = mk_code(3'd6, 7'b0101010);
         "@": c = mk_code(3'd5, 7'b0101000);
         "$": c = mk_code(3'd6, 7'b0001010);
         "%": c = mk_code(3'd7, 7'b1000101);
         "*": c = mk_code(3'd5, 7'b1010100);
         " ": begin
            c       = mk_code(3'd1, 7'b0000000);
            c.space = 1'b1;
         end
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

/* sv/mkq_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkq_csr
// Configuration register file; write-only, one register per index.
// ----------------------------------------------------------------------------
module mkq_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [mkq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mkq_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output mkq_pkg::cfg_type                cfg
);

   mkq_pkg::cfg_type cfg_ff;
   mkq_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (mkq_pkg::csr_index_type'(csr_index))
            mkq_pkg::CSR_TX_MODE:      cfg_in.tx_mode        = csr_wdata[0];
            mkq_pkg::CSR_DOT_TIME:     cfg_in.dot_time_ms    = csr_wdata;
            mkq_pkg::CSR_DASH_RATIO:   cfg_in.dash_ratio     = csr_wdata[3:0];
            mkq_pkg::CSR_GAP_TIME:     cfg_in.gap_time_ms    = csr_wdata;
            mkq_pkg::CSR_PTT_DELAY:    cfg_in.ptt_delay_ms   = csr_wdata;
            mkq_pkg::CSR_BEACON_PAUSE: cfg_in.beacon_pause_s = csr_wdata[11:0];
            mkq_pkg::CSR_SIDETONE_EN:  cfg_in.sidetone_en    = csr_wdata[0];
            mkq_pkg::CSR_BEACON_FLAGS: cfg_in.beacon_flags   = csr_wdata[1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tx_mode        <= 1'b0;
         cfg_ff.dot_time_ms    <= 16'd1000;
         cfg_ff.dash_ratio     <= 4'd3;
         cfg_ff.gap_time_ms    <= 16'd100;
         cfg_ff.ptt_delay_ms   <= 16'd500;
         cfg_ff.beacon_pause_s <= 12'd60;
         cfg_ff.sidetone_en    <= 1'b0;
         cfg_ff.beacon_flags   <= 2'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/mkq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkq_ctrl
// Segment sequencer: walks lead, elements, gaps, bad-character, stop and message end per item.
// ----------------------------------------------------------------------------
module mkq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mkq_pkg::dp_status_type sts,
   output mkq_pkg::ctrl_cmd_type  cmd
);

   mkq_pkg::state_type state_ff;
   mkq_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mkq_pkg::ST_IDLE: begin
            if (req_valid) state_in = mkq_pkg::ST_DISPATCH;
         end
         mkq_pkg::ST_DISPATCH: begin
            priority if (sts.stop)   state_in = sts.active ? mkq_pkg::ST_STOP
                                                           : mkq_pkg::ST_IDLE;
            else if (!sts.active)    state_in = mkq_pkg::ST_LEAD;
            else if (sts.bad)        state_in = mkq_pkg::ST_BAD;
            else                     state_in = mkq_pkg::ST_ELEM;
         end
         mkq_pkg::ST_LEAD: begin
            if (sts.out_free) state_in = sts.bad ? mkq_pkg::ST_BAD : mkq_pkg::ST_ELEM;
         end
         mkq_pkg::ST_BAD: begin
            if (sts.out_free) state_in = sts.last_char ? mkq_pkg::ST_END : mkq_pkg::ST_IDLE;
         end
         mkq_pkg::ST_ELEM: begin
            if (sts.out_free) begin
               priority if (sts.gap_after)  state_in = mkq_pkg::ST_EGAP;
               else if (!sts.elem_last)     state_in = mkq_pkg::ST_ELEM;
               else if (sts.last_char)      state_in = mkq_pkg::ST_END;
               else                         state_in = mkq_pkg::ST_LGAP;
            end
         end
         mkq_pkg::ST_EGAP: begin
            if (sts.out_free) state_in = mkq_pkg::ST_ELEM;
         end
         mkq_pkg::ST_LGAP, mkq_pkg::ST_END, mkq_pkg::ST_STOP: begin
            if (sts.out_free) state_in = mkq_pkg::ST_IDLE;
         end
         default: state_in = mkq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = (state_ff != mkq_pkg::ST_IDLE);
      cmd.load    = (state_ff == mkq_pkg::ST_IDLE) && req_valid;
      cmd.emit    = 1'b0;
      cmd.seg     = mkq_pkg::SEG_LEAD;
      cmd.last    = 1'b0;
      cmd.idx_adv = 1'b0;
      unique case (state_ff)
         mkq_pkg::ST_IDLE, mkq_pkg::ST_DISPATCH: begin
            cmd.emit = 1'b0;
         end
         mkq_pkg::ST_LEAD: begin
            cmd.emit = sts.out_free;
            cmd.seg  = mkq_pkg::SEG_LEAD;
         end
         mkq_pkg::ST_BAD: begin
            cmd.emit = sts.out_free;
            cmd.seg  = mkq_pkg::SEG_BAD;
            cmd.last = !sts.last_char;
         end
         mkq_pkg::ST_ELEM: begin
            cmd.emit    = sts.out_free;
            cmd.seg     = mkq_pkg::SEG_ELEM;
            cmd.idx_adv = sts.out_free && !sts.gap_after && !sts.elem_last;
         end
         mkq_pkg::ST_EGAP: begin
            cmd.emit    = sts.out_free;
            cmd.seg     = mkq_pkg::SEG_EGAP;
            cmd.idx_adv = sts.out_free;
         end
         mkq_pkg::ST_LGAP: begin
            cmd.emit = sts.out_free;
            cmd.seg  = mkq_pkg::SEG_LGAP;
            cmd.last = 1'b1;
         end
         mkq_pkg::ST_END: begin
            cmd.emit = sts.out_free;
            cmd.seg  = mkq_pkg::SEG_END;
            cmd.last = 1'b1;
         end
         mkq_pkg::ST_STOP: begin
            cmd.emit = sts.out_free;
            cmd.seg  = mkq_pkg::SEG_STOP;
            cmd.last = 1'b1;
         end
         default: cmd.emit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mkq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/mkq_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkq_dpath
// Item registers, code lookup, segment timing arithmetic and output register.
// ----------------------------------------------------------------------------
module mkq_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  mkq_pkg::cfg_type                cfg,
   input  mkq_pkg::ctrl_cmd_type           cmd,
   output mkq_pkg::dp_status_type          sts,
   input  logic                            req_cmd,
   input  logic [7:0]                      req_ch,
   input  logic                            req_last_char,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_key_line,
   output logic                            rsp_ptt_line,
   output logic [1:0]                      rsp_tone,
   output logic [mkq_pkg::DUR_W-1:0]       rsp_duration_ms,
   output logic                            rsp_bad_char,
   output logic                            rsp_msg_end,
   output logic                            rsp_last
);

   logic                               stop_ff;
   logic                               last_char_ff;
   mkq_pkg::morse_code_type            code_ff;
   logic [mkq_pkg::CODE_LEN_W-1:0]     idx_ff;
   logic [mkq_pkg::CODE_LEN_W-1:0]     idx_in;
   logic                               active_ff, active_in;
   logic                               ptt_level_ff, ptt_level_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               key_ff, key_in;
   logic                               ptt_ff, ptt_in;
   logic [1:0]                         tone_ff, tone_in;
   logic [mkq_pkg::DUR_W-1:0]          dur_ff, dur_in;
   logic                               bad_ff, bad_in;
   logic                               end_ff, end_in;
   logic                               last_ff, last_in;

   logic                               dfcw;
   logic                               elem_dash;
   logic                               elem_last;
   logic                               beacon_key;
   logic [mkq_pkg::DUR_W-1:0]          dot_ms, dash_ms, five_ms, three_ms;
   logic [mkq_pkg::DUR_W-1:0]          gap_ms, delay_ms, pause_ms, dfcw_on_ms;

   assign dfcw      = cfg.tx_mode;
   assign elem_dash = code_ff.pattern[3'(mkq_pkg::CODE_MAX - 1) - idx_ff];
   assign elem_last = (idx_ff == code_ff.len - 3'd1);

   assign dot_ms     = mkq_pkg::DUR_W'(cfg.dot_time_ms);
   assign gap_ms     = mkq_pkg::DUR_W'(cfg.gap_time_ms);
   assign delay_ms   = mkq_pkg::DUR_W'(cfg.ptt_delay_ms);
   assign dash_ms    = mkq_pkg::DUR_W'(cfg.dash_ratio) * dot_ms;
   assign five_ms    = (dot_ms << 2) + dot_ms;
   assign three_ms   = (dot_ms << 1) + dot_ms;
   assign pause_ms   = mkq_pkg::DUR_W'(cfg.beacon_pause_s) * mkq_pkg::MS_PER_S;
   // DFCW dot on-time clips at zero
   assign dfcw_on_ms = (cfg.dot_time_ms > cfg.gap_time_ms) ? (dot_ms - gap_ms) : '0;
   assign beacon_key = cfg.beacon_flags[1];

   assign sts.stop      = stop_ff;
   assign sts.active    = active_ff;
   assign sts.bad       = !code_ff.found;
   assign sts.last_char = last_char_ff;
   assign sts.elem_last = elem_last;
   assign sts.gap_after = !elem_last && (!dfcw || (!code_ff.space && !elem_dash));
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      active_in    = active_ff;
      ptt_level_in = ptt_level_ff;
      idx_in       = idx_ff;
      key_in       = 1'b0;
      ptt_in       = ptt_level_ff;
      tone_in      = mkq_pkg::TONE_NONE;
      dur_in       = '0;
      bad_in       = 1'b0;
      end_in       = 1'b0;
      last_in      = cmd.last;

      if (cmd.load) begin
         idx_in = '0;
         if (!req_cmd && !dfcw) ptt_level_in = 1'b1;
      end
      if (cmd.idx_adv) idx_in = idx_ff + 3'd1;

      unique case (cmd.seg)
         mkq_pkg::SEG_LEAD: begin
            active_in = cmd.emit ? 1'b1 : active_ff;
            key_in    = dfcw;
            ptt_in    = dfcw ? ptt_level_ff : 1'b1;
            dur_in    = delay_ms;
         end
         mkq_pkg::SEG_BAD: begin
            bad_in = 1'b1;
         end
         mkq_pkg::SEG_ELEM: begin
            priority if (code_ff.space) begin
               ptt_in = dfcw ? ptt_level_ff : 1'b1;
               dur_in = dfcw ? three_ms : five_ms;
            end else if (!dfcw) begin
               key_in  = 1'b1;
               ptt_in  = 1'b1;
               tone_in = cfg.sidetone_en ? mkq_pkg::TONE_SIDE : mkq_pkg::TONE_NONE;
               dur_in  = elem_dash ? dash_ms : dot_ms;
            end else begin
               // DFCW moves the PTT line: low for dash, high for dot
               key_in       = 1'b1;
               ptt_in       = !elem_dash;
               ptt_level_in = cmd.emit ? !elem_dash : ptt_level_ff;
               if (cfg.sidetone_en) begin
                  tone_in = elem_dash ? mkq_pkg::TONE_DASH : mkq_pkg::TONE_DOT;
               end
               dur_in = elem_dash ? dot_ms : dfcw_on_ms;
            end
         end
         mkq_pkg::SEG_EGAP: begin
            ptt_in = dfcw ? ptt_level_ff : 1'b1;
            dur_in = dfcw ? gap_ms : dot_ms;
         end
         mkq_pkg::SEG_LGAP: begin
            ptt_in = dfcw ? ptt_level_ff : 1'b1;
            dur_in = dfcw ? three_ms : five_ms;
         end
         mkq_pkg::SEG_END, mkq_pkg::SEG_STOP: begin
            priority if (dfcw) begin
               ptt_in = 1'b0;
               end_in = 1'b1;
            end else if (cmd.seg == mkq_pkg::SEG_END && cfg.beacon_flags[0]) begin
               // beacon pause keeps the transmission open
               key_in  = beacon_key;
               ptt_in  = 1'b1;
               tone_in = (beacon_key && cfg.sidetone_en) ? mkq_pkg::TONE_SIDE
                                                         : mkq_pkg::TONE_NONE;
               dur_in  = pause_ms;
            end else begin
               ptt_in = 1'b1;
               dur_in = delay_ms;
               end_in = 1'b1;
            end
            if (end_in && cmd.emit) begin
               active_in    = 1'b0;
               ptt_level_in = 1'b0;
            end
         end
         default: dur_in = '0;
      endcase

      if (cmd.emit)          rsp_valid_in = 1'b1;
      else if (!rsp_stall)   rsp_valid_in = 1'b0;
      else                   rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         ptt_level_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         ptt_level_ff <= ptt_level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load) begin
         stop_ff      <= req_cmd;
         last_char_ff <= req_last_char;
         code_ff      <= mkq_pkg::code_lookup(req_ch);
      end
      if (cmd.emit) begin
         key_ff  <= key_in;
         ptt_ff  <= ptt_in;
         tone_ff <= tone_in;
         dur_ff  <= dur_in;
         bad_ff  <= bad_in;
         end_ff  <= end_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_key_line    = key_ff;
   assign rsp_ptt_line    = ptt_ff;
   assign rsp_tone        = tone_ff;
   assign rsp_duration_ms = dur_ff;
   assign rsp_bad_char    = bad_ff;
   assign rsp_msg_end     = end_ff;
   assign rsp_last        = last_ff;

endmodule

/* sv/morse_keyer_qrss_dfcw_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_keyer_qrss_dfcw_top
// QRSS / DFCW Morse keyer: characters in, timed key/PTT line segments out.
// ----------------------------------------------------------------------------
// Each accepted transaction is a character or a stop command. A character is
// looked up case-insensitively and turned into line segments (key, PTT, tone,
// duration in ms), the last one flagged with rsp_last; an unknown character
// yields one zero-length segment with rsp_bad_char set. A stop while idle
// produces nothing. An item is accepted, then decoded, then sends one segment per
// cycle into the output register; the sequencer handles one item at a time and
// the output register stalls it while rsp_stall is high. Write configuration
// only while the block is idle.
// ----------------------------------------------------------------------------
module morse_keyer_qrss_dfcw_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_cmd,
   input  logic [7:0]                      req_ch,
   input  logic                            req_last_char,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_key_line,
   output logic                            rsp_ptt_line,
   output logic [1:0]                      rsp_tone,
   output logic [mkq_pkg::DUR_W-1:0]       rsp_duration_ms,
   output logic                            rsp_bad_char,
   output logic                            rsp_msg_end,
   output logic                            rsp_last,
   input  logic                            csr_wr_en,
   input  logic [mkq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mkq_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   mkq_pkg::cfg_type       cfg;
   mkq_pkg::ctrl_cmd_type  cmd;
   mkq_pkg::dp_status_type sts;

   mkq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mkq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mkq_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .sts             (sts),
      .req_cmd         (req_cmd),
      .req_ch          (req_ch),
      .req_last_char   (req_last_char),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_key_line    (rsp_key_line),
      .rsp_ptt_line    (rsp_ptt_line),
      .rsp_tone        (rsp_tone),
      .rsp_duration_ms (rsp_duration_ms),
      .rsp_bad_char    (rsp_bad_char),
      .rsp_msg_end     (rsp_msg_end),
      .rsp_last        (rsp_last)
   );

endmodule

/* bench/tb_morse_keyer_qrss_dfcw_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_morse_keyer_qrss_dfcw_top
// Self-checking bench for the QRSS / DFCW Morse keyer.
// ----------------------------------------------------------------------------
// A short directed table covers reset defaults, register extremes, both modes,
// word spaces, unknown characters, stops and beacon pauses. Random messages
// follow under changing register settings. Every accepted character or stop
// is run through a local keyer model; each line segment that comes out is
// checked field by field against the oldest segment still expected. Both
// handshakes get random idle bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module tb_morse_keyer_qrss_dfcw_top;

   localparam int N_ITEMS      = 330;
   localparam int QUIET_ITEMS  = 40;
   localparam int PHASE_ITEMS  = 40;
   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum logic {CMD_CHAR = 1'b0, CMD_STOP = 1'b1} cmd_type;
   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic                      key;
      logic                      ptt;
      mkq_pkg::tone_type         tone;
      logic [mkq_pkg::DUR_W-1:0] dur;
      logic                      bad;
      logic                      msg_end;
      logic                      last;
   } segment_type;

   typedef struct {
      row_kind_type           kind;
      mkq_pkg::csr_index_type idx;
      logic [15:0]            wdata;
      cmd_type                cmd;
      logic [7:0]             ch;
      logic                   last_char;
      int                     n_typed;   // -1: take the keyer model's segments
   } stim_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_cmd = 1'b0;
   logic [7:0]                     req_ch = 8'h00;
   logic                           req_last_char = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic                           rsp_key_line;
   logic                           rsp_ptt_line;
   logic [1:0]                     rsp_tone;
   logic [mkq_pkg::DUR_W-1:0]      rsp_duration_ms;
   logic                           rsp_bad_char;
   logic                           rsp_msg_end;
   logic                           rsp_last;
   logic                           csr_wr_en = 1'b0;
   mkq_pkg::csr_index_type         csr_index = mkq_pkg::CSR_TX_MODE;
   logic [mkq_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   mkq_pkg::cfg_type shadow_cfg;
   logic             tx_active;
   logic             tx_ptt;
   segment_type      burst[$];
   segment_type      segments_due[$];
   segment_type      typed_segs[$];
   stim_row_type     directed[$];
   int               mismatches = 0;
   int               item_cnt = 0;
   int               cycles = 0;
   bit               quiet = 1'b0;
   bit               calm = 1'b0;
   int               stall_left = 0;

   morse_keyer_qrss_dfcw_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_ch          (req_ch),
      .req_last_char   (req_last_char),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_key_line    (rsp_key_line),
      .rsp_ptt_line    (rsp_ptt_line),
      .rsp_tone        (rsp_tone),
      .rsp_duration_ms (rsp_duration_ms),
      .rsp_bad_char    (rsp_bad_char),
      .rsp_msg_end     (rsp_msg_end),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- model

   function automatic segment_type mk_seg(input logic key, input logic ptt,
                                          input mkq_pkg::tone_type tone,
                                          input int unsigned dur, input logic bad,
                                          input logic fin, input logic lst);
      segment_type s;
      s.key     = key;
      s.ptt     = ptt;
      s.tone    = tone;
      s.dur     = dur[mkq_pkg::DUR_W-1:0];
      s.bad     = bad;
      s.msg_end = fin;
      s.last    = lst;
      return s;
   endfunction

   function automatic string morse_of(input logic [7:0] ch);
      logic [7:0] uc;
      uc = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
      case (uc)
         "A": return ".-";     "B": return "-...";   "C": return "-.-.";
         "D": return "-..";    "E": return ".";      "F": return "..-.";
         "G": return "--.";    "H": return "....";   "I": return "..";
         "J": return ".---";   "K": return "-.-";    "L": return ".-..";
         "M": return "--";     "N": return "-.";     "O": return "---";
         "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
         "S": return "...";    "T": return "-";      "U": return "..-";
         "V": return "...-";   "W": return ".--";    "X": return "-..-";
         "Y": return "-.--";   "Z": return "--..";   "0": return "-----";
         "1": return ".----";  "2": return "..---";  "3": return "...--";
         "4": return "....-";  "5": return ".....";  "6": return "-....";
         "7": return "--...";  "8": return "---..";  "9": return "----.";
         "?": return "..--.."; "/": return "-..-.";  ".": return ".-.-.-";
         "@": return ".-.-.";  "$": return "...-.-"; "%": return "-...-.-";
         "*": return "-.-.-";  " ": return " ";
         default: return "";
      endcase
   endfunction

   function automatic void close_tx(input logic dfcw, input logic allow_beacon);
      logic k;
      k = shadow_cfg.beacon_flags[1];
      if (dfcw) begin
         burst.push_back(mk_seg(1'b0, 1'b0, mkq_pkg::TONE_NONE, 32'd0, 1'b0, 1'b1, 1'b0));
         tx_active = 1'b0;
         tx_ptt    = 1'b0;
      end else if (allow_beacon && shadow_cfg.beacon_flags[0]) begin
         // beacon pause keeps the transmission open
         burst.push_back(mk_seg(k, 1'b1,
                                (k && shadow_cfg.sidetone_en) ? mkq_pkg::TONE_SIDE
                                                              : mkq_pkg::TONE_NONE,
                                32'(shadow_cfg.beacon_pause_s) * 32'd1000,
                                1'b0, 1'b0, 1'b0));
      end else begin
         burst.push_back(mk_seg(1'b0, 1'b1, mkq_pkg::TONE_NONE,
                                32'(shadow_cfg.ptt_delay_ms), 1'b0, 1'b1, 1'b0));
         tx_active = 1'b0;
         tx_ptt    = 1'b0;
      end
   endfunction

   // Fill burst with the segments that one transaction produces.
   function automatic void predict_segments(input cmd_type cmd, input logic [7:0] ch,
                                            input logic last_char);
      logic        dfcw;
      logic        side;
      string       code;
      int          i;
      int unsigned dot;
      int unsigned gap;
      int unsigned on_ms;
      dfcw = shadow_cfg.tx_mode;
      side = shadow_cfg.sidetone_en;
      dot  = 32'(shadow_cfg.dot_time_ms);
      gap  = 32'(shadow_cfg.gap_time_ms);
      burst.delete();
      if (cmd == CMD_STOP) begin
         if (tx_active) close_tx(dfcw, 1'b0);
      end else begin
         if (!tx_active) begin
            tx_active = 1'b1;
            if (dfcw) begin
               burst.push_back(mk_seg(1'b1, tx_ptt, mkq_pkg::TONE_NONE,
                                      32'(shadow_cfg.ptt_delay_ms), 1'b0, 1'b0, 1'b0));
            end else begin
               burst.push_back(mk_seg(1'b0, 1'b1, mkq_pkg::TONE_NONE,
                                      32'(shadow_cfg.ptt_delay_ms), 1'b0, 1'b0, 1'b0));
            end
         end
         if (!dfcw) tx_ptt = 1'b1;
         code = morse_of(ch);
         if (code.len() == 0) begin
            // unknown character: flag it, no letter gap
            burst.push_back(mk_seg(1'b0, tx_ptt, mkq_pkg::TONE_NONE, 32'd0,
                                   1'b1, 1'b0, 1'b0));
            if (last_char) close_tx(dfcw, 1'b1);
         end else begin
            for (i = 0; i < code.len(); i++) begin
               if (!dfcw) begin
                  if (code[i] == "-") begin
                     burst.push_back(mk_seg(1'b1, 1'b1,
                                            side ? mkq_pkg::TONE_SIDE : mkq_pkg::TONE_NONE,
                                            32'(shadow_cfg.dash_ratio) * dot,
                                            1'b0, 1'b0, 1'b0));
                  end else if (code[i] == ".") begin
                     burst.push_back(mk_seg(1'b1, 1'b1,
                                            side ? mkq_pkg::TONE_SIDE : mkq_pkg::TONE_NONE,
                                            dot, 1'b0, 1'b0, 1'b0));
                  end else begin
                     burst.push_back(mk_seg(1'b0, 1'b1, mkq_pkg::TONE_NONE, 32'd5 * dot,
                                            1'b0, 1'b0, 1'b0));
                  end
                  if (i < code.len() - 1) begin
                     burst.push_back(mk_seg(1'b0, 1'b1, mkq_pkg::TONE_NONE, dot,
                                            1'b0, 1'b0, 1'b0));
                  end
               end else begin
                  if (code[i] == "-") begin
                     tx_ptt = 1'b0;
                     burst.push_back(mk_seg(1'b1, 1'b0,
                                            side ? mkq_pkg::TONE_DASH : mkq_pkg::TONE_NONE,
                                            dot, 1'b0, 1'b0, 1'b0));
                  end else if (code[i] == ".") begin
                     // on-time floors at zero when the gap exceeds the dot
                     on_ms  = (dot > gap) ? dot - gap : 32'd0;
                     tx_ptt = 1'b1;
                     burst.push_back(mk_seg(1'b1, 1'b1,
                                            side ? mkq_pkg::TONE_DOT : mkq_pkg::TONE_NONE,
                                            on_ms, 1'b0, 1'b0, 1'b0));
                  end else begin
                     burst.push_back(mk_seg(1'b0, tx_ptt, mkq_pkg::TONE_NONE, 32'd3 * dot,
                                            1'b0, 1'b0, 1'b0));
                  end
                  if (i < code.len() - 1 && code[i] == ".") begin
                     burst.push_back(mk_seg(1'b0, tx_ptt, mkq_pkg::TONE_NONE, gap,
                                            1'b0, 1'b0, 1'b0));
                  end
               end
            end
            if (!last_char) begin
               if (!dfcw) begin
                  burst.push_back(mk_seg(1'b0, 1'b1, mkq_pkg::TONE_NONE, 32'd5 * dot,
                                         1'b0, 1'b0, 1'b0));
               end else begin
                  burst.push_back(mk_seg(1'b0, tx_ptt, mkq_pkg::TONE_NONE, 32'd3 * dot,
                                         1'b0, 1'b0, 1'b0));
               end
            end else begin
               close_tx(dfcw, 1'b1);
            end
         end
      end
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_item(input cmd_type cmd, input logic [7:0] ch,
                            input logic last_char, input int n_typed);
      int k;
      if (!quiet && $urandom_range(0, 2) == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 8)) @(negedge clock);
      end
      @(negedge clock);
      req_valid     = 1'b1;
      req_cmd       = cmd;
      req_ch        = ch;
      req_last_char = last_char;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_segments(cmd, ch, last_char);
      if (burst.size() > 0) item_cnt++;
      if (n_typed < 0) begin
         for (k = 0; k < burst.size(); k++) segments_due.push_back(burst[k]);
      end else begin
         for (k = 0; k < n_typed; k++) segments_due.push_back(typed_segs.pop_front());
      end
   endtask

   // Drop valid, wait for every expected segment, then let the block finish.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (segments_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input mkq_pkg::csr_index_type idx, input logic [15:0] val);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         mkq_pkg::CSR_TX_MODE:      shadow_cfg.tx_mode        = val[0];
         mkq_pkg::CSR_DOT_TIME:     shadow_cfg.dot_time_ms    = val;
         mkq_pkg::CSR_DASH_RATIO:   shadow_cfg.dash_ratio     = val[3:0];
         mkq_pkg::CSR_GAP_TIME:     shadow_cfg.gap_time_ms    = val;
         mkq_pkg::CSR_PTT_DELAY:    shadow_cfg.ptt_delay_ms   = val;
         mkq_pkg::CSR_BEACON_PAUSE: shadow_cfg.beacon_pause_s = val[11:0];
         mkq_pkg::CSR_SIDETONE_EN:  shadow_cfg.sidetone_en    = val[0];
         mkq_pkg::CSR_BEACON_FLAGS: shadow_cfg.beacon_flags   = val[1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic stim_row_type item_row(input cmd_type cmd, input logic [7:0] ch,
                                             input logic last_char, input int n_typed);
      stim_row_type r;
      r.kind      = ROW_ITEM;
      r.idx       = mkq_pkg::CSR_TX_MODE;
      r.wdata     = '0;
      r.cmd       = cmd;
      r.ch        = ch;
      r.last_char = last_char;
      r.n_typed   = n_typed;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input mkq_pkg::csr_index_type idx,
                                            input logic [15:0] val);
      stim_row_type r;
      r       = item_row(CMD_CHAR, 8'h00, 1'b0, -1);
      r.kind  = ROW_CSR;
      r.idx   = idx;
      r.wdata = val;
      return r;
   endfunction

   function automatic logic [7:0] pick_char();
      string      charset;
      logic [7:0] c;
      charset = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789?/.@$%* ";
      c = charset[$urandom_range(0, charset.len() - 1)];
      if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) c = c + 8'd32;
      return c;
   endfunction

   task automatic random_setup(input int phase);
      int          i;
      logic [15:0] v;
      settle();
      for (i = 0; i < 8; i++) begin
         case ($urandom_range(0, 3))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            default: v = 16'($urandom_range(0, 65535));
         endcase
         if (i == 0) v[0] = phase[0];
         csr_write(mkq_pkg::csr_index_type'(i[2:0]), v);
      end
   endtask

   // Mostly well-formed messages; some carry a stray byte, get cut by a stop,
   // or are plain noise.
   task automatic random_message();
      int         n;
      int         k;
      int         style;
      int         spot;
      logic [7:0] c;
      n     = $urandom_range(1, 8);
      style = $urandom_range(0, 9);
      spot  = $urandom_range(0, n - 1);
      if (style == 0) begin
         send_item(cmd_type'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), -1);
      end else begin
         for (k = 0; k < n; k++) begin
            c = pick_char();
            if (style == 1 && k == spot) c = 8'($urandom_range(0, 255));
            if (style == 2 && k == n - 1) begin
               send_item(CMD_STOP, c, 1'($urandom_range(0, 1)), -1);
            end else begin
               send_item(CMD_CHAR, c, k == n - 1, -1);
            end
         end
      end
      if (!quiet && $urandom_range(0, 15) == 0) settle();
   endtask

   // ---------------------------------------------------------------- receiver

   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) calm = !calm;
      if (stall_left != 0) begin
         stall_left--;
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = 1'b0;
         if (!quiet && !calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
      end
   end

   function automatic void cmp_field(input string name, input int unsigned want,
                                     input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      segment_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (segments_due.size() == 0) begin
            $display("%0t: segment with nothing expected, expected none, actual dur %0d",
                     $time, rsp_duration_ms);
            mismatches++;
         end else begin
            want = segments_due.pop_front();
            cmp_field("key_line", 32'(want.key), 32'(rsp_key_line));
            cmp_field("ptt_line", 32'(want.ptt), 32'(rsp_ptt_line));
            cmp_field("tone", 32'(want.tone), 32'(rsp_tone));
            cmp_field("duration_ms", 32'(want.dur), 32'(rsp_duration_ms));
            cmp_field("bad_char", 32'(want.bad), 32'(rsp_bad_char));
            cmp_field("msg_end", 32'(want.msg_end), 32'(rsp_msg_end));
            cmp_field("last", 32'(want.last), 32'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int           i;
      int           phase;
      int           phase_start;
      stim_row_type row;

      shadow_cfg = '{tx_mode: 1'b0, dot_time_ms: 16'd1000, dash_ratio: 4'd3,
                     gap_time_ms: 16'd100, ptt_delay_ms: 16'd500, beacon_pause_s: 12'd60,
                     sidetone_en: 1'b0, beacon_flags: 2'd0};
      tx_active = 1'b0;
      tx_ptt    = 1'b0;

      // QRSS defaults after reset
      directed.push_back(item_row(CMD_STOP, 8'h00, 1'b0, 0));
      directed.push_back(item_row(CMD_CHAR, "E", 1'b1, 3));
      typed_segs.push_back(mk_seg(1'b0, 1'b1, mkq_pkg::TONE_NONE, 32'd500,
                                  1'b0, 1'b0, 1'b0));
      typed_segs.push_back(mk_seg(1'b1, 1'b1, mkq_pkg::TONE_NONE, 32'd1000,
                                  1'b0, 1'b0, 1'b0));
      typed_segs.push_back(mk_seg(1'b0, 1'b1, mkq_pkg::TONE_NONE, 32'd500,
                                  1'b0, 1'b1, 1'b1));
      directed.push_back(item_row(CMD_CHAR, "a", 1'b0, -1));
      directed.push_back(item_row(CMD_CHAR, 8'h00, 1'b0, 1));
      typed_segs.push_back(mk_seg(1'b0, 1'b1, mkq_pkg::TONE_NONE, 32'd0,
                                  1'b1, 1'b0, 1'b1));
      directed.push_back(item_row(CMD_CHAR, " ", 1'b0, -1));
      directed.push_back(item_row(CMD_CHAR, "%", 1'b0, -1));
      directed.push_back(item_row(CMD_CHAR, 8'hFF, 1'b1, 2));
      typed_segs.push_back(mk_seg(1'b0, 1'b1, mkq_pkg::TONE_NONE, 32'd0,
                                  1'b1, 1'b0, 1'b0));
      typed_segs.push_back(mk_seg(1'b0, 1'b1, mkq_pkg::TONE_NONE, 32'd500,
                                  1'b0, 1'b1, 1'b1));
      // QRSS beacon with key down, long dots
      directed.push_back(csr_row(mkq_pkg::CSR_SIDETONE_EN, 16'h0001));
      directed.push_back(csr_row(mkq_pkg::CSR_BEACON_FLAGS, 16'h0003));
      directed.push_back(csr_row(mkq_pkg::CSR_BEACON_PAUSE, 16'h0FFF));
      directed.push_back(csr_row(mkq_pkg::CSR_DOT_TIME, 16'hFFFF));
      directed.push_back(csr_row(mkq_pkg::CSR_DASH_RATIO, 16'h000F));
      directed.push_back(item_row(CMD_CHAR, "z", 1'b1, -1));
      directed.push_back(item_row(CMD_CHAR, "0", 1'b0, -1));
      directed.push_back(item_row(CMD_STOP, "0", 1'b1, 1));
      typed_segs.push_back(mk_seg(1'b0, 1'b1, mkq_pkg::TONE_NONE, 32'd500,
                                  1'b0, 1'b1, 1'b1));
      // DFCW with the gap longer than the dot
      directed.push_back(csr_row(mkq_pkg::CSR_TX_MODE, 16'h0001));
      directed.push_back(csr_row(mkq_pkg::CSR_DOT_TIME, 16'h0001));
      directed.push_back(csr_row(mkq_pkg::CSR_GAP_TIME, 16'hFFFF));
      directed.push_back(csr_row(mkq_pkg::CSR_PTT_DELAY, 16'h0000));
      directed.push_back(csr_row(mkq_pkg::CSR_BEACON_FLAGS, 16'h0001));
      directed.push_back(csr_row(mkq_pkg::CSR_DASH_RATIO, 16'h0000));
      directed.push_back(item_row(CMD_CHAR, "R", 1'b0, -1));
      directed.push_back(item_row(CMD_CHAR, "?", 1'b0, -1));
      directed.push_back(item_row(CMD_CHAR, " ", 1'b0, -1));
      directed.push_back(item_row(CMD_CHAR, "x", 1'b1, -1));
      directed.push_back(item_row(CMD_CHAR, "k", 1'b0, -1));
      directed.push_back(item_row(CMD_CHAR, 8'h7F, 1'b0, -1));
      directed.push_back(item_row(CMD_STOP, 8'h00, 1'b0, 1));
      typed_segs.push_back(mk_seg(1'b0, 1'b0, mkq_pkg::TONE_NONE, 32'd0,
                                  1'b0, 1'b1, 1'b1));
      directed.push_back(item_row(CMD_STOP, 8'hFF, 1'b1, 0));
      // back to QRSS, beacon bit off, long lead
      directed.push_back(csr_row(mkq_pkg::CSR_SIDETONE_EN, 16'h0000));
      directed.push_back(csr_row(mkq_pkg::CSR_DOT_TIME, 16'd300));
      directed.push_back(csr_row(mkq_pkg::CSR_GAP_TIME, 16'h0000));
      directed.push_back(csr_row(mkq_pkg::CSR_PTT_DELAY, 16'hFFFF));
      directed.push_back(csr_row(mkq_pkg::CSR_BEACON_PAUSE, 16'h0000));
      directed.push_back(csr_row(mkq_pkg::CSR_BEACON_FLAGS, 16'h0002));
      directed.push_back(csr_row(mkq_pkg::CSR_TX_MODE, 16'h0000));
      directed.push_back(csr_row(mkq_pkg::CSR_DASH_RATIO, 16'h0001));
      directed.push_back(item_row(CMD_CHAR, "@", 1'b0, -1));
      directed.push_back(item_row(CMD_CHAR, "$", 1'b0, -1));
      directed.push_back(item_row(CMD_CHAR, "/", 1'b0, -1));
      directed.push_back(item_row(CMD_CHAR, "*", 1'b1, -1));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < directed.size(); i++) begin
         row = directed[i];
         if (row.kind == ROW_CSR) begin
            settle();
            csr_write(row.idx, row.wdata);
         end else begin
            send_item(row.cmd, row.ch, row.last_char, row.n_typed);
         end
      end

      phase       = 0;
      phase_start = item_cnt;
      random_setup(phase);
      while (item_cnt < N_ITEMS) begin
         if (item_cnt >= N_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         if (item_cnt - phase_start >= PHASE_ITEMS) begin
            phase++;
            phase_start = item_cnt;
            random_setup(phase);
         end
         random_message();
      end

      settle();
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
